// File: rtl/tag_delimited_text_extractor_defines.svh
// assertion macros for the tag delimited text extractor
// the using module supplies clk and rst_n; empty bodies when SYNTH is defined
`ifndef TAG_DELIMITED_TEXT_EXTRACTOR_DEFINES_SVH
`define TAG_DELIMITED_TEXT_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH

`define TDE_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tde: forbidden condition seen");

`define TDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tde: expected next-cycle condition missing");

`else

`define TDE_ASSERT_NEVER(label, cond)

`define TDE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/tde_pkg.sv
// shared types, register codes and tag helpers for the text extractor
// no dependencies
package tde_pkg;

  localparam int MAX_TAG_LEN_DEF = 8;
  localparam int MAX_START_TAGS  = 3;
  localparam int TAG_W           = 64;
  localparam int LEN_W           = 4;
  localparam int POS_W           = 3;
  localparam int REG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [15:0] TAG_LENGTHS_RST = 16'h1111;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_FIRST  = 3'd0,
    REG_START_SECOND = 3'd1,
    REG_START_THIRD  = 3'd2,
    REG_END_CHARS    = 3'd3,
    REG_TAG_LENGTHS  = 3'd4,
    REG_START_COUNT  = 3'd5,
    REG_REPEAT_MODE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [MAX_START_TAGS-1:0][TAG_W-1:0] open_tag;
    logic [TAG_W-1:0]                     end_tag;
    logic [15:0]                          tag_lengths;
    logic [1:0]                           start_tag_count;
    logic                                 repeat_mode;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    open_tag:        '0,
    end_tag:         '0,
    tag_lengths:     TAG_LENGTHS_RST,
    start_tag_count: 2'd1,
    repeat_mode:     1'b0
  };

  typedef struct packed {
    logic       is_end;
    logic [7:0] text;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [LEN_W-1:0] tag_len(input logic [LEN_W-1:0] nib,
                                               input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] n;
    n = nib;
    if (n == '0) n = LEN_W'(1);
    if (n > max_len) n = max_len;
    return n;
  endfunction

  function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] tag,
                                          input logic [POS_W-1:0] idx);
    return tag[{idx, 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/tde_front.sv
// front end: start and end tag matching, turns bytes into queue ops
// depends on tde_pkg
module tde_front #(
  parameter int MAX_TAG_LEN = tde_pkg::MAX_TAG_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tde_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  tde_pkg::q_stat_t  q_stat,
  output logic              push,
  output tde_pkg::op_t      push_op
);

  logic [1:0]                      stage_r, stage_nxt;
  logic [tde_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                            finished_r, finished_nxt;
  logic [1:0]                      cnt;
  logic                            capturing;
  logic [tde_pkg::TAG_W-1:0]       tag_sel;
  logic [tde_pkg::LEN_W-1:0]       nib;
  logic [tde_pkg::LEN_W-1:0]       len;
  logic [tde_pkg::LEN_W-1:0]       npos;
  logic                            done;
  logic                            accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (cfg.start_tag_count == 2'd0) begin
      cnt = 2'd1;
    end else if (cfg.start_tag_count > 2'(tde_pkg::MAX_START_TAGS)) begin
      cnt = 2'(tde_pkg::MAX_START_TAGS);
    end else begin
      cnt = cfg.start_tag_count;
    end
  end

  assign capturing = (stage_r >= cnt);

  always_comb begin
    if (capturing) begin
      tag_sel = cfg.end_tag;
      nib     = cfg.tag_lengths[15:12];
    end else begin
      case (stage_r)
        2'd1: begin
          tag_sel = cfg.open_tag[1];
          nib     = cfg.tag_lengths[7:4];
        end
        2'd2: begin
          tag_sel = cfg.open_tag[2];
          nib     = cfg.tag_lengths[11:8];
        end
        default: begin
          tag_sel = cfg.open_tag[0];
          nib     = cfg.tag_lengths[3:0];
        end
      endcase
    end
  end

  assign len = tde_pkg::tag_len(nib, tde_pkg::LEN_W'(MAX_TAG_LEN));

  always_comb begin
    if (in_data_byte == tde_pkg::tag_char(tag_sel, pos_r)) begin
      npos = {1'b0, pos_r} + tde_pkg::LEN_W'(1);
    end else if (in_data_byte == tde_pkg::tag_char(tag_sel, '0)) begin
      npos = tde_pkg::LEN_W'(1);
    end else begin
      npos = '0;
    end
  end

  assign done = (npos >= len);

  always_comb begin
    stage_nxt    = stage_r;
    pos_nxt      = pos_r;
    finished_nxt = finished_r;
    push         = 1'b0;
    push_op      = '0;
    if (accept && !finished_r) begin
      pos_nxt = done ? '0 : npos[tde_pkg::POS_W-1:0];
      if (!capturing) begin
        if (done) stage_nxt = stage_r + 2'd1;
      end else begin
        push = 1'b1;
        if (done) begin
          push_op.is_end = 1'b1;
          if (cfg.repeat_mode) stage_nxt = 2'd0;
          else finished_nxt = 1'b1;
        end else begin
          push_op.text = in_data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= 2'd0;
      pos_r      <= '0;
      finished_r <= 1'b0;
    end else begin
      stage_r    <= stage_nxt;
      pos_r      <= pos_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

// File: rtl/tde_queue.sv
// short op queue between the matching front end and the holdback back end
// depends on tde_pkg
module tde_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tde_pkg::op_t      push_op,
  input  logic              pop,
  output logic              q_valid,
  output tde_pkg::op_t      q_op,
  output tde_pkg::q_stat_t  q_stat
);

  localparam int DEPTH = tde_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tde_pkg::op_t       mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_valid      = !q_stat.empty;
  assign q_op         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

endmodule

// File: rtl/tde_back.sv
// back end: end-tag holdback delay line and output register
// depends on tde_pkg
module tde_back #(
  parameter int MAX_TAG_LEN = tde_pkg::MAX_TAG_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tde_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  tde_pkg::op_t   q_op,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_text_byte,
  output logic           out_capture_end
);

  localparam int IDX_W = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;

  logic [7:0]                  hb_r   [MAX_TAG_LEN];
  logic [7:0]                  hb_nxt [MAX_TAG_LEN];
  logic [IDX_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  text_r, text_nxt;
  logic                        end_r, end_nxt;
  logic [tde_pkg::LEN_W-1:0]   end_len;
  logic [tde_pkg::LEN_W-1:0]   cap;
  logic                        fill;
  logic                        out_free;

  assign end_len  = tde_pkg::tag_len(cfg.tag_lengths[15:12],
                                     tde_pkg::LEN_W'(MAX_TAG_LEN));
  assign cap      = end_len - tde_pkg::LEN_W'(1);
  assign fill     = !q_op.is_end && (tde_pkg::LEN_W'(cnt_r) < cap);
  assign out_free = !out_valid_r || out_ready;
  assign pop      = q_valid && (fill || out_free);

  assign out_valid       = out_valid_r;
  assign out_text_byte   = text_r;
  assign out_capture_end = end_r;

  always_comb begin
    hb_nxt        = hb_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    text_nxt      = text_r;
    end_nxt       = end_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (pop) begin
      if (q_op.is_end) begin
        cnt_nxt       = '0;
        out_valid_nxt = 1'b1;
        text_nxt      = 8'd0;
        end_nxt       = 1'b1;
      end else if (fill) begin
        hb_nxt[cnt_r] = q_op.text;
        cnt_nxt       = cnt_r + IDX_W'(1);
      end else if (cnt_r == '0) begin
        out_valid_nxt = 1'b1;
        text_nxt      = q_op.text;
        end_nxt       = 1'b0;
      end else begin
        out_valid_nxt = 1'b1;
        text_nxt      = hb_r[0];
        end_nxt       = 1'b0;
        for (int i = 0; i < MAX_TAG_LEN - 1; i++) begin
          if (IDX_W'(i) < cnt_r - IDX_W'(1)) hb_nxt[i] = hb_r[i+1];
        end
        hb_nxt[cnt_r - IDX_W'(1)] = q_op.text;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_r   <= hb_nxt;
    text_r <= text_nxt;
    end_r  <= end_nxt;
  end

endmodule

// File: rtl/tag_delimited_text_extractor.sv
// tag delimited text extractor: one byte per cycle while in_ready is high, captured text between tags
// path: an accepted byte is written into the op queue, and the back end then pops it into the
// holdback line or into the registered output that drives out_valid
// throughput: one byte per cycle while the 2-entry op queue has room; out_ready stalls can fill it
// reset: synchronous active-low rst_n clears match state, queue and holdback count,
// returns config registers to defaults; output valid drops; no clearing pass
`include "tag_delimited_text_extractor_defines.svh"

module tag_delimited_text_extractor #(
  parameter int MAX_TAG_LEN = tde_pkg::MAX_TAG_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tde_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [tde_pkg::TAG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_text_byte,
  output logic                               out_capture_end
);

  tde_pkg::cfg_t     cfg_r, cfg_nxt;
  tde_pkg::q_stat_t  q_stat;
  tde_pkg::op_t      push_op;
  tde_pkg::op_t      q_op;
  logic              push;
  logic              pop;
  logic              q_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (tde_pkg::reg_idx_t'(cfg_index))
        tde_pkg::REG_START_FIRST:  cfg_nxt.open_tag[0]     = cfg_data;
        tde_pkg::REG_START_SECOND: cfg_nxt.open_tag[1]     = cfg_data;
        tde_pkg::REG_START_THIRD:  cfg_nxt.open_tag[2]     = cfg_data;
        tde_pkg::REG_END_CHARS:    cfg_nxt.end_tag         = cfg_data;
        tde_pkg::REG_TAG_LENGTHS:  cfg_nxt.tag_lengths     = cfg_data[15:0];
        tde_pkg::REG_START_COUNT:  cfg_nxt.start_tag_count = cfg_data[1:0];
        tde_pkg::REG_REPEAT_MODE:  cfg_nxt.repeat_mode     = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tde_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tde_front #(
    .MAX_TAG_LEN (MAX_TAG_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_op      (push_op)
  );

  tde_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_stat  (q_stat)
  );

  tde_back #(
    .MAX_TAG_LEN (MAX_TAG_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_op            (q_op),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_text_byte   (out_text_byte),
    .out_capture_end (out_capture_end)
  );

  `TDE_ASSERT_NEVER(a_q_full_empty, q_stat.full && q_stat.empty)
  `TDE_ASSERT_NEVER(a_pop_empty, pop && q_stat.empty)
  `TDE_ASSERT_NEXT(a_push_lands, push && q_stat.empty, !q_stat.empty)
  `TDE_ASSERT_NEXT(a_pop_frees, pop && !push && q_stat.full, !q_stat.full)

endmodule

// File: sim/tb_tag_delimited_text_extractor.sv
// testbench for tag_delimited_text_extractor: directed and random byte streams,
// random config phases and idling on both channels, results checked against a predictor
// depends on rtl/tde_pkg.sv and rtl/tag_delimited_text_extractor.sv

class text_capture_model;
  logic [63:0]  tags [4];
  logic [15:0]  lens;
  logic [1:0]   cnt;
  logic         rpt;
  int           stage;
  int           pos;
  int           held_n;
  bit           done;
  logic [7:0]   held [8];
  tde_pkg::op_t expected_text [$];
  int           errors;

  function new();
    foreach (tags[i]) tags[i] = '0;
    foreach (held[i]) held[i] = '0;
    lens = tde_pkg::TAG_LENGTHS_RST;
    cnt = 2'd1;
    rpt = 1'b0;
    stage = 0;
    pos = 0;
    held_n = 0;
    done = 1'b0;
    errors = 0;
  endfunction

  function int tag_len(int k);
    int n;
    n = int'(lens[4 * (k & 3) +: 4]);
    if (n == 0) n = 1;
    if (n > tde_pkg::MAX_TAG_LEN_DEF) n = tde_pkg::MAX_TAG_LEN_DEF;
    return n;
  endfunction

  function logic [7:0] tag_char(int k, int i);
    return tags[k & 3][8 * (i & 7) +: 8];
  endfunction

  function int start_count();
    return (cnt == 2'd0) ? 1 : int'(cnt);
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      tde_pkg::REG_START_FIRST, tde_pkg::REG_START_SECOND, tde_pkg::REG_START_THIRD,
      tde_pkg::REG_END_CHARS: tags[idx] = data;
      tde_pkg::REG_TAG_LENGTHS: lens = data[15:0];
      tde_pkg::REG_START_COUNT: cnt = data[1:0];
      tde_pkg::REG_REPEAT_MODE: rpt = data[0];
      default: ;
    endcase
  endfunction

  // naive match: on a miss the same byte is retried against the first char
  function bit advance(int k, logic [7:0] b);
    int p;
    int n;
    n = tag_len(k);
    p = pos & 7;
    if (b == tag_char(k, p)) p = p + 1;
    else if (b == tag_char(k, 0)) p = 1;
    else p = 0;
    if (p >= n) begin
      pos = 0;
      return 1'b1;
    end
    pos = p;
    return 1'b0;
  endfunction

  function void take_byte(logic [7:0] b);
    int room;
    tde_pkg::op_t r;
    if (done) return;
    if (stage < start_count()) begin
      if (advance(stage, b)) stage = (stage + 1) & 3;
      return;
    end
    r.is_end = 1'b0;
    r.text = b;
    if (advance(tde_pkg::REG_END_CHARS, b)) begin
      held_n = 0;
      if (rpt) stage = 0;
      else done = 1'b1;
      r.is_end = 1'b1;
      r.text = '0;
      expected_text.insert(expected_text.size(), r);
      return;
    end
    room = tag_len(tde_pkg::REG_END_CHARS) - 1;
    if (held_n < room) begin
      held[held_n & 7] = b;
      held_n++;
      return;
    end
    if (held_n != 0) begin
      r.text = held[0];
      for (int i = 0; i + 1 < held_n; i++) held[i] = held[i + 1];
      held[(held_n - 1) & 7] = b;
    end
    expected_text.insert(expected_text.size(), r);
  endfunction

  task flag_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_text(logic [7:0] text, logic is_end);
    tde_pkg::op_t want;
    if (expected_text.size() == 0) begin
      flag_mismatch($sformatf("unexpected result text=%02h end=%b", text, is_end));
      return;
    end
    want = expected_text.pop_front();
    if (is_end !== want.is_end)
      flag_mismatch($sformatf("capture_end %b, want %b (text=%02h)", is_end, want.is_end, text));
    else if (!is_end && text !== want.text)
      flag_mismatch($sformatf("text_byte %02h, want %02h", text, want.text));
  endtask
endclass

module tb_tag_delimited_text_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 100;
  localparam int          IDLE_LIMIT  = 2000;
  localparam logic [2:0]  REG_SPARE   = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_text_byte;
  logic        out_capture_end;

  text_capture_model sb;
  int gap_odds;
  int stall_odds;
  int sent;

  tag_delimited_text_extractor dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_text(out_text_byte, out_capture_end);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.take_byte(in_data_byte);
    end
  end

  initial begin : result_sink
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tag_delimited_text_extractor regression: fail");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(input tde_pkg::cfg_t c);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(tde_pkg::REG_START_FIRST, c.open_tag[0]);
    write_reg(tde_pkg::REG_START_SECOND, c.open_tag[1]);
    write_reg(tde_pkg::REG_START_THIRD, c.open_tag[2]);
    write_reg(tde_pkg::REG_END_CHARS, c.end_tag);
    write_reg(tde_pkg::REG_TAG_LENGTHS, {junk[63:16], c.tag_lengths});
    write_reg(tde_pkg::REG_START_COUNT, {junk[63:2], c.start_tag_count});
    write_reg(tde_pkg::REG_REPEAT_MODE, {junk[63:1], c.repeat_mode});
    write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // hold off input until every expected result has come, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_text.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // start tags, text and end tag; some noise, some sequences cut short
  task automatic emit_sequence();
    int kind;
    int n;
    int cut;
    int len;
    kind = $urandom_range(0, 9);
    n = sb.start_count();
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
      return;
    end
    cut = (kind == 1) ? $urandom_range(0, n - 1) : n;
    for (int k = 0; k < n; k++) begin
      len = sb.tag_len(k);
      if (k == cut) len = $urandom_range(0, len - 1);
      for (int j = 0; j < len; j++) push_byte(sb.tag_char(k, j));
      if (k == cut) break;
    end
    repeat ($urandom_range(0, 12)) begin
      if ($urandom_range(0, 7) == 0)
        push_byte(sb.tag_char(tde_pkg::REG_END_CHARS, $urandom_range(0, 7)));
      else
        push_byte(8'($urandom_range(0, 255)));
    end
    len = sb.tag_len(tde_pkg::REG_END_CHARS);
    if (kind == 2) len = $urandom_range(0, len - 1);
    for (int j = 0; j < len; j++) push_byte(sb.tag_char(tde_pkg::REG_END_CHARS, j));
  endtask

  initial begin
    int goal;
    logic [7:0] alpha [4];
    logic [63:0] tag;
    logic [3:0] nib;
    tde_pkg::cfg_t c;
    logic [7:0] burst [$];

    sb = new();
    sent = 0;
    gap_odds = 3;
    stall_odds = 3;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // two start tags, end tag of three: restart on a miss, broken end tag in text
    c = '0;
    c.open_tag[0] = 64'h6D1E_93A7_C4B2_FF00;
    c.open_tag[1] = 64'h0F0F_F0F0_55AA_3C42;
    c.open_tag[2] = 64'hFFFF_0000_1234_5A5A;
    c.end_tag = 64'h8001_7FFE_A53E_2F3C;
    c.tag_lengths = 16'h3212;
    c.start_tag_count = 2'd2;
    c.repeat_mode = 1'b1;
    load_regs(c);
    burst = '{8'h00, 8'h00, 8'hFF, 8'h42, 8'h11, 8'hFF, 8'h3C, 8'h00, 8'h3C, 8'h2F,
              8'h3E, 8'h3E, 8'h3C, 8'h00, 8'hFF, 8'h42, 8'hAA, 8'h3C};
    foreach (burst[i]) push_byte(burst[i]);

    // count raised and end tag shortened while bytes are held
    drain_results();
    c.tag_lengths = 16'h1212;
    c.start_tag_count = 2'd3;
    load_regs(c);
    burst = '{8'h5A, 8'h5A, 8'h01, 8'h3C, 8'h00};
    foreach (burst[i]) push_byte(burst[i]);

    // first tag shortened below the match position
    drain_results();
    c.tag_lengths = 16'h1211;
    load_regs(c);
    push_byte(8'hFF);
    push_byte(8'h42);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      foreach (alpha[j]) alpha[j] = 8'($urandom_range(0, 255));
      for (int k = 0; k < 4; k++) begin
        tag = {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
          if ($urandom_range(0, 3) != 0) tag[8 * i +: 8] = alpha[$urandom_range(0, 3)];
        if (k < 3) c.open_tag[k] = tag;
        else c.end_tag = tag;
        case ($urandom_range(0, 9))
          0: nib = 4'd0;
          1: nib = 4'd8;
          2: nib = 4'($urandom_range(9, 15));
          default: nib = 4'($urandom_range(1, 4));
        endcase
        c.tag_lengths[4 * k +: 4] = nib;
      end
      c.start_tag_count = 2'($urandom_range(0, 3));
      if (ph == 0) begin
        c.tag_lengths = 16'h8888;
        c.start_tag_count = 2'd3;
      end
      if (ph == 1) begin
        c.tag_lengths = 16'h0000;
        c.start_tag_count = 2'd0;
      end
      if (ph == 2) c.tag_lengths = 16'hFFFF;
      c.repeat_mode = (ph != PHASES - 1);
      load_regs(c);
      gap_odds = (ph >= PHASES - 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      stall_odds = (ph >= PHASES - 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        if (sb.done) begin
          // one-shot capture over: a few bytes that must be dropped
          repeat (8) push_byte(8'($urandom_range(0, 255)));
          break;
        end
        emit_sequence();
      end
    end

    drain_results();
    if (sb.errors == 0)
      $display("tag_delimited_text_extractor regression: pass");
    else
      $display("tag_delimited_text_extractor regression: fail");
    $finish;
  end
endmodule
